>>> rtl/core/cbt_pkg.sv
// shared constants, types and codes for the can bit timing calculator
`timescale 1ns / 1ps
`default_nettype none

package cbt_pkg;

  // search limits
  localparam int PRESCALER_TRIES = 15;
  localparam int MIN_QUANTA      = 8;
  localparam int MAX_QUANTA      = 25;

  // port field widths
  localparam int OSC_W      = 6;
  localparam int RATE_W     = 10;
  localparam int PCT_W      = 7;
  localparam int SJW_W      = 2;
  localparam int PRE_W      = 4;
  localparam int NQ_W       = 5;
  localparam int SEG_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int CODE6_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  // cell row: one cell per candidate quanta count
  localparam int NUM_CELLS   = MAX_QUANTA - MIN_QUANTA + 1;
  localparam int FILL_CYCLES = NUM_CELLS + 1;
  localparam int CNT_W       = $clog2((FILL_CYCLES > PRESCALER_TRIES) ?
                                      FILL_CYCLES : PRESCALER_TRIES);

  // internal arithmetic widths
  localparam int TICKS_W = $clog2(((1 << OSC_W) - 1) * 1000 + 1);
  localparam int RATE2_W = RATE_W + 1;
  localparam int STEP_W  = $clog2(MAX_QUANTA * ((1 << RATE2_W) - 2) + 1);
  localparam int ACC_RAW = $clog2(MAX_QUANTA * PRESCALER_TRIES * ((1 << RATE2_W) - 2) + 1);
  localparam int ACC_W   = (ACC_RAW > TICKS_W) ? ACC_RAW : TICKS_W;
  localparam int N_W     = $clog2(MAX_QUANTA + 1);
  localparam int PCT_ROUND = 50;
  localparam int PROD_W  = $clog2(MAX_QUANTA * ((1 << PCT_W) - 1) + PCT_ROUND + 1);

  // divide by 100 as multiply by 1311 and shift by 17, exact below 4200
  localparam int RECIP_100 = 1311;
  localparam int RECIP_SH  = 17;
  localparam int S_W       = 6;
  localparam int MUL_W     = RECIP_SH + S_W;
  localparam int DIFF_W    = 8;

  localparam logic signed [DIFF_W-1:0] PHASE_MIN_S = DIFF_W'(2);
  localparam logic signed [DIFF_W-1:0] SEG_MAX_S   = DIFF_W'(8);
  localparam logic signed [DIFF_W-1:0] PROP_MIN_S  = DIFF_W'(1);
  localparam logic signed [DIFF_W-1:0] ONE_S       = DIFF_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_LENGTH_MODE    = 0,
    REG_TRIPLE_SAMPLE      = 1,
    REG_START_OF_FRAME_PIN = 2,
    REG_WAKE_FILTER        = 3
  } cfg_reg_e;

  typedef struct packed {
    logic bit_length_mode;
    logic triple_sample;
    logic start_of_frame_pin;
    logic wake_filter;
  } cfg_t;

  // values every cell sees for the current transaction
  typedef struct packed {
    logic [RATE2_W-1:0] rate2;
    logic [PCT_W-1:0]   pct;
    logic [SJW_W-1:0]   sjw;
    logic [TICKS_W-1:0] ticks;
  } cmn_t;

  // handed from one cell to the next
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [PROD_W-1:0] prod;
    logic [N_W-1:0]    n;
  } link_t;

  typedef struct packed {
    logic acc_load;
    logic acc_add;
  } cell_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [N_W-1:0]   n;
    logic [SEG_W-1:0] b;
    logic [SEG_W-1:0] p;
  } cell_res_t;

  typedef struct packed {
    logic              found;
    logic [PRE_W-1:0]  prescaler;
    logic [NQ_W-1:0]   quanta_per_bit;
    logic [SEG_W-1:0]  prop_segment;
    logic [SEG_W-1:0]  phase_one;
    logic [SEG_W-1:0]  phase_two;
    logic [BYTE_W-1:0] timing_byte_one;
    logic [BYTE_W-1:0] timing_byte_two;
    logic [BYTE_W-1:0] timing_byte_three;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FILL = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/cbt_if.sv
// valid/ready channel interfaces for input, result and configuration
`timescale 1ns / 1ps
`default_nettype none

interface cbt_in_if;
  logic                        valid;
  logic                        ready;
  logic [cbt_pkg::OSC_W-1:0]   osc_mhz;
  logic [cbt_pkg::RATE_W-1:0]  bit_rate_kbps;
  logic [cbt_pkg::PCT_W-1:0]   sample_pct;
  logic [cbt_pkg::SJW_W-1:0]   jump_width;

  modport source (output valid, osc_mhz, bit_rate_kbps, sample_pct, jump_width,
                  input ready);
  modport sink (input valid, osc_mhz, bit_rate_kbps, sample_pct, jump_width,
                output ready);
endinterface

interface cbt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [cbt_pkg::PRE_W-1:0]   prescaler;
  logic [cbt_pkg::NQ_W-1:0]    quanta_per_bit;
  logic [cbt_pkg::SEG_W-1:0]   prop_segment;
  logic [cbt_pkg::SEG_W-1:0]   phase_one;
  logic [cbt_pkg::SEG_W-1:0]   phase_two;
  logic [cbt_pkg::BYTE_W-1:0]  timing_byte_one;
  logic [cbt_pkg::BYTE_W-1:0]  timing_byte_two;
  logic [cbt_pkg::BYTE_W-1:0]  timing_byte_three;

  modport source (output valid, found, prescaler, quanta_per_bit, prop_segment,
                  phase_one, phase_two, timing_byte_one, timing_byte_two,
                  timing_byte_three,
                  input ready);
  modport sink (input valid, found, prescaler, quanta_per_bit, prop_segment,
                phase_one, phase_two, timing_byte_one, timing_byte_two,
                timing_byte_three,
                output ready);
endinterface

interface cbt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cbt_pkg::CFG_IDX_W-1:0]  index;
  logic [cbt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cbt_cell.sv
// one cell of the row: tests one quanta count against each prescaler code scanned
`timescale 1ns / 1ps
`default_nettype none

module cbt_cell (
  input  logic               clk,
  input  cbt_pkg::cmn_t      cmn,
  input  cbt_pkg::cell_ctl_t ctl,
  input  cbt_pkg::link_t     link_in,
  output cbt_pkg::link_t     link_out,
  output cbt_pkg::cell_res_t res
);
  import cbt_pkg::*;

  link_t                    link_r, link_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic                     ok_r, ok_nxt;
  logic [SEG_W-1:0]         b_r, p_r;
  logic [MUL_W-1:0]         prod_x;
  logic [S_W-1:0]           samp;
  logic signed [DIFF_W-1:0] b_s, p_s, sjw_min;

  always_comb begin
    // step = n * 2 * rate, prod = n * pct + 50, both built from the left neighbor
    link_nxt.step = link_in.step + STEP_W'(cmn.rate2);
    link_nxt.prod = link_in.prod + PROD_W'(cmn.pct);
    link_nxt.n    = link_in.n + N_W'(1);

    // rounded sample point, then phase 2 and propagation lengths
    prod_x  = MUL_W'(link_r.prod) * MUL_W'(RECIP_100);
    samp    = prod_x[RECIP_SH +: S_W];
    b_s     = $signed(DIFF_W'(link_r.n)) - $signed(DIFF_W'(samp));
    p_s     = $signed(DIFF_W'(link_r.n)) - ONE_S - (b_s <<< 1);
    sjw_min = $signed(DIFF_W'(cmn.sjw)) + ONE_S;
    ok_nxt  = (b_s >= PHASE_MIN_S) && (b_s <= SEG_MAX_S) &&
              (p_s >= PROP_MIN_S) && (p_s <= SEG_MAX_S) && (b_s >= sjw_min);

    // acc walks n * 2 * rate * (code + 1) over the prescaler codes
    if (ctl.acc_load) begin
      acc_nxt = ACC_W'(link_nxt.step);
    end else if (ctl.acc_add) begin
      acc_nxt = acc_r + ACC_W'(link_r.step);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    link_r <= link_nxt;
    acc_r  <= acc_nxt;
    ok_r   <= ok_nxt;
    b_r    <= SEG_W'(b_s);
    p_r    <= SEG_W'(p_s);
  end

  assign link_out = link_r;
  assign res.hit  = ok_r && (acc_r == ACC_W'(cmn.ticks));
  assign res.n    = link_r.n;
  assign res.b    = b_r;
  assign res.p    = p_r;

endmodule

`default_nettype wire

>>> rtl/core/cbt_ctrl.sv
// sequencer: fills the cell row, scans prescaler codes, holds the result
`timescale 1ns / 1ps
`default_nettype none

module cbt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                rate_zero,
  input  logic [cbt_pkg::SJW_W-1:0] sjw,
  input  cbt_pkg::cfg_t       cfg,
  input  cbt_pkg::cell_res_t  cell_res [cbt_pkg::NUM_CELLS],
  output cbt_pkg::cell_ctl_t  ctl,
  input  logic                out_ready,
  output logic                out_valid,
  output cbt_pkg::result_t    result
);
  import cbt_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt, res_build;
  logic             any_hit, found_now, last_code, fill_end, finish, out_free;
  logic [N_W-1:0]   sel_n;
  logic [SEG_W-1:0] sel_b, sel_p;

  // at most one cell can hit for a given code, so an or-merge selects it
  always_comb begin
    any_hit = 1'b0;
    sel_n   = '0;
    sel_b   = '0;
    sel_p   = '0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      any_hit = any_hit | cell_res[k].hit;
      sel_n   = sel_n | (cell_res[k].n & {N_W{cell_res[k].hit}});
      sel_b   = sel_b | (cell_res[k].b & {SEG_W{cell_res[k].hit}});
      sel_p   = sel_p | (cell_res[k].p & {SEG_W{cell_res[k].hit}});
    end
  end

  always_comb begin
    found_now = any_hit && !rate_zero;
    last_code = (cnt_r == CNT_W'(PRESCALER_TRIES - 1));
    fill_end  = (cnt_r == CNT_W'(FILL_CYCLES - 1));
    finish    = found_now || last_code || rate_zero;
    out_free  = !out_valid_r || out_ready;

    res_build = '0;
    if (found_now) begin
      res_build.found             = 1'b1;
      res_build.prescaler         = PRE_W'(cnt_r);
      res_build.quanta_per_bit    = NQ_W'(sel_n);
      res_build.prop_segment      = sel_p;
      res_build.phase_one         = sel_b;
      res_build.phase_two         = sel_b;
      res_build.timing_byte_one   = {sjw, CODE6_W'(cnt_r)};
      res_build.timing_byte_two   = {cfg.bit_length_mode, cfg.triple_sample,
                                     3'(sel_b - SEG_W'(1)), 3'(sel_p - SEG_W'(1))};
      res_build.timing_byte_three = {cfg.start_of_frame_pin, cfg.wake_filter,
                                     6'(sel_b - SEG_W'(1))};
    end

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    ctl           = '0;
    in_ready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_FILL;
          cnt_nxt   = '0;
        end
      end
      ST_FILL: begin
        ctl.acc_load = 1'b1;
        if (fill_end) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        if (finish) begin
          // wait here while the previous result is still unclaimed
          if (out_free) begin
            res_nxt       = res_build;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          ctl.acc_add = 1'b1;
          cnt_nxt     = cnt_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule

`default_nettype wire

>>> rtl/core/can_bit_timing_calculator.sv
// top level of the can bit timing calculator
// Each input transaction gives one result transaction. After an item is taken, a row of 18
// cells (one per quanta count 8 to 25) fills from left to right, then the prescaler codes
// are scanned one per cycle, stopping at the first code that fits (for a zero bit rate the
// scan stops at the first code), and the result is registered. A finished result waits in
// the scan while the previous one is still unread. A new item is taken in the cycle after
// the result is loaded, even if that result is still waiting to be read, so a new item is
// never taken while the previous one is still in the row. Configuration writes are taken
// every cycle; the mode bits are read when a result is built, so they are written only
// while no item is in flight: the user must keep to this, as the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module can_bit_timing_calculator (
  input logic       clk,
  input logic       rst_n,
  cbt_in_if.sink    in_if,
  cbt_out_if.source out_if,
  cbt_cfg_if.sink   cfg_if
);
  import cbt_pkg::*;

  cfg_t       cfg_r;
  cmn_t       cmn_r;
  link_t      link0_r;
  logic       rate_zero_r;
  logic       in_fire;
  cell_ctl_t  ctl;
  cell_res_t  cell_res [NUM_CELLS];
  link_t      link [NUM_CELLS];
  result_t    result;

  assign in_fire = in_if.valid && in_if.ready;

  // configuration registers
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_reg_e'(cfg_if.index))
        REG_BIT_LENGTH_MODE:    cfg_r.bit_length_mode    <= cfg_if.data[0];
        REG_TRIPLE_SAMPLE:      cfg_r.triple_sample      <= cfg_if.data[0];
        REG_START_OF_FRAME_PIN: cfg_r.start_of_frame_pin <= cfg_if.data[0];
        REG_WAKE_FILTER:        cfg_r.wake_filter        <= cfg_if.data[0];
        default: begin
        end
      endcase
    end
  end

  // capture the transaction and the seed for the left end of the row
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmn_r.rate2  <= {in_if.bit_rate_kbps, 1'b0};
      cmn_r.pct    <= in_if.sample_pct;
      cmn_r.sjw    <= in_if.jump_width;
      cmn_r.ticks  <= TICKS_W'(int'(in_if.osc_mhz) * 1000);
      link0_r.step <= STEP_W'(int'(in_if.bit_rate_kbps) * 2 * (MIN_QUANTA - 1));
      link0_r.prod <= PROD_W'(int'(in_if.sample_pct) * (MIN_QUANTA - 1) + PCT_ROUND);
      link0_r.n    <= N_W'(MIN_QUANTA - 1);
      rate_zero_r  <= (in_if.bit_rate_kbps == '0);
    end
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    if (g == 0) begin : g_first
      cbt_cell u_cell (
        .clk      (clk),
        .cmn      (cmn_r),
        .ctl      (ctl),
        .link_in  (link0_r),
        .link_out (link[g]),
        .res      (cell_res[g])
      );
    end else begin : g_rest
      cbt_cell u_cell (
        .clk      (clk),
        .cmn      (cmn_r),
        .ctl      (ctl),
        .link_in  (link[g-1]),
        .link_out (link[g]),
        .res      (cell_res[g])
      );
    end
  end

  cbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .rate_zero (rate_zero_r),
    .sjw       (cmn_r.sjw),
    .cfg       (cfg_r),
    .cell_res  (cell_res),
    .ctl       (ctl),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .result    (result)
  );

  assign out_if.found             = result.found;
  assign out_if.prescaler         = result.prescaler;
  assign out_if.quanta_per_bit    = result.quanta_per_bit;
  assign out_if.prop_segment      = result.prop_segment;
  assign out_if.phase_one         = result.phase_one;
  assign out_if.phase_two         = result.phase_two;
  assign out_if.timing_byte_one   = result.timing_byte_one;
  assign out_if.timing_byte_two   = result.timing_byte_two;
  assign out_if.timing_byte_three = result.timing_byte_three;

  // a miss reports all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.found) |->
      (out_if.prescaler == '0) && (out_if.quanta_per_bit == '0) &&
      (out_if.timing_byte_two == '0) && (out_if.timing_byte_three == '0))
    else $error("miss result carries nonzero fields");

  // a hit has equal phase segments within limits and a legal quanta count
  a_hit_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.found) |->
      (out_if.phase_one == out_if.phase_two) &&
      (out_if.phase_two >= SEG_W'(2)) && (out_if.phase_two <= SEG_W'(8)) &&
      (out_if.prop_segment >= SEG_W'(1)) && (out_if.prop_segment <= SEG_W'(8)) &&
      (out_if.quanta_per_bit >= NQ_W'(MIN_QUANTA)))
    else $error("hit result outside segment limits");

  // no result can appear right after a transaction is taken: the row must fill first
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !$rose(out_if.valid))
    else $error("result raised directly after input transaction");

endmodule

`default_nettype wire
